### rtl/core/bhd_pkg.sv
// Shared types and constants for the byte histogram with descending drain.
`timescale 1ns / 1ps

package bhd_pkg;

  // Fixed widths of the stream fields.
  localparam int unsigned IN_SYMBOL_W  = 8;
  localparam int unsigned OUT_SYMBOL_W = 8;
  localparam int unsigned OUT_COUNT_W  = 16;
  localparam int unsigned OUT_DATA_W   = OUT_SYMBOL_W + OUT_COUNT_W;

  // Item kinds carried on the input tuser.
  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_count;  // count item accepted: read its counter and bitmap row
    logic start_drain;  // drain item accepted: pick the top row, read it
    logic count_update; // write back the incremented counter and row
    logic drain_pick;   // pick the top symbol in the row, clear its bit
    logic drain_emit;   // load the result into the output register
  } cmd_t;

endpackage

### rtl/core/bhd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bhd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/bhd_ctrl.sv
// Controller state machine: sequences count and drain items and owns the output valid.
`timescale 1ns / 1ps

module bhd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_kind_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bhd_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CNT_UPD,
    ST_DRN_PICK,
    ST_DRN_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind_i == bhd_pkg::KIND_DRAIN) begin
            cmd_o.start_drain = 1'b1;
            state_d           = ST_DRN_PICK;
          end else begin
            cmd_o.start_count = 1'b1;
            state_d           = ST_CNT_UPD;
          end
        end
      end
      ST_CNT_UPD: begin
        cmd_o.count_update = 1'b1;
        state_d            = ST_IDLE;
      end
      ST_DRN_PICK: begin
        cmd_o.drain_pick = 1'b1;
        state_d          = ST_DRN_OUT;
      end
      ST_DRN_OUT: begin
        if (slot_free) begin
          cmd_o.drain_emit = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/bhd_datapath.sv
// Datapath: counter RAM, nonzero bitmap in rows with a row summary, result register.
`timescale 1ns / 1ps

module bhd_datapath #(
  parameter int unsigned SYMBOL_BITS = 8,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bhd_pkg::cmd_t                       cmd_i,
  input  logic [bhd_pkg::IN_SYMBOL_W-1:0]     in_symbol_i,
  output logic [bhd_pkg::OUT_SYMBOL_W-1:0]    out_symbol_o,
  output logic [bhd_pkg::OUT_COUNT_W-1:0]     out_count_o,
  output logic                                is_empty_o,
  output logic                                is_last_o
);

  localparam int unsigned SW    = SYMBOL_BITS;
  localparam int unsigned HI_W  = SYMBOL_BITS / 2;
  localparam int unsigned LO_W  = SYMBOL_BITS - HI_W;
  localparam int unsigned ROWS  = 1 << HI_W;
  localparam int unsigned ROW_N = 1 << LO_W;
  localparam int unsigned NSYM  = 1 << SYMBOL_BITS;
  localparam int unsigned OSW   = bhd_pkg::OUT_SYMBOL_W;
  localparam int unsigned OCW   = bhd_pkg::OUT_COUNT_W;

  function automatic logic [HI_W-1:0] top_of_summary(input logic [ROWS-1:0] v);
    logic [HI_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (v[i]) begin
        idx = HI_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [LO_W-1:0] top_of_row(input logic [ROW_N-1:0] v);
    logic [LO_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < ROW_N; i++) begin
      if (v[i]) begin
        idx = LO_W'(i);
      end
    end
    return idx;
  endfunction

  // Row summary: a set bit means the row may hold nonzero entries and its RAM word is valid.
  logic [ROWS-1:0]  summary_q, summary_d;
  logic [SW-1:0]    sym_q;
  logic [HI_W-1:0]  top_hi_q;
  logic [LO_W-1:0]  top_lo_q;
  logic             any_q;
  logic             last_q;
  logic [OSW-1:0]   out_symbol_q;
  logic [OCW-1:0]   out_count_q;
  logic             is_empty_q;
  logic             is_last_q;

  logic [SW-1:0]         sym_in;
  logic [HI_W-1:0]       sym_hi;
  logic [LO_W-1:0]       sym_lo;
  logic [HI_W-1:0]       enc_hi;
  logic [LO_W-1:0]       enc_lo;
  logic [ROW_N-1:0]      row_rd;
  logic [ROW_N-1:0]      row_word;
  logic [ROW_N-1:0]      cleared_row;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_next;
  logic                  do_pick;

  logic                  cnt_re, cnt_we;
  logic [SW-1:0]         cnt_raddr;
  logic                  row_re, row_we;
  logic [HI_W-1:0]       row_raddr, row_waddr;
  logic [ROW_N-1:0]      row_wdata;

  assign sym_in  = SW'(in_symbol_i);
  assign sym_hi  = sym_q[SW-1:LO_W];
  assign sym_lo  = sym_q[LO_W-1:0];
  assign enc_hi  = top_of_summary(summary_q);
  assign do_pick = cmd_i.drain_pick && any_q;

  // A row whose summary bit is clear reads as all zeros, whatever the RAM holds.
  assign row_word    = summary_q[cmd_i.drain_pick ? top_hi_q : sym_hi] ? row_rd : '0;
  assign enc_lo      = top_of_row(row_word);
  assign cleared_row = row_word & ~(ROW_N'(1) << enc_lo);

  assign cnt_cur  = row_word[sym_lo] ? cnt_rd : '0;
  assign cnt_next = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_BITS'(1);

  assign cnt_re    = cmd_i.start_count || do_pick;
  assign cnt_raddr = cmd_i.start_count ? sym_in : {top_hi_q, enc_lo};
  assign cnt_we    = cmd_i.count_update;

  assign row_re    = cmd_i.start_count || cmd_i.start_drain;
  assign row_raddr = cmd_i.start_drain ? enc_hi : sym_in[SW-1:LO_W];
  assign row_we    = cmd_i.count_update || do_pick;
  assign row_waddr = do_pick ? top_hi_q : sym_hi;
  assign row_wdata = do_pick ? cleared_row : (row_word | (ROW_N'(1) << sym_lo));

  always_comb begin
    summary_d = summary_q;
    if (cmd_i.count_update) begin
      summary_d[sym_hi] = 1'b1;
    end else if (do_pick) begin
      summary_d[top_hi_q] = |cleared_row;
    end
  end

  bhd_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NSYM)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (sym_q),
    .wdata_i (cnt_next),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rd)
  );

  bhd_ram #(
    .WIDTH (ROW_N),
    .DEPTH (ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      summary_q <= '0;
    end else begin
      summary_q <= summary_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_count) begin
      sym_q <= sym_in;
    end
    if (cmd_i.start_drain) begin
      top_hi_q <= enc_hi;
      any_q    <= |summary_q;
    end
    if (do_pick) begin
      top_lo_q <= enc_lo;
      last_q   <= (summary_d == '0);
    end
    if (cmd_i.drain_emit) begin
      out_symbol_q <= any_q ? OSW'({top_hi_q, top_lo_q}) : '0;
      out_count_q  <= any_q ? OCW'(cnt_rd) : '0;
      is_empty_q   <= !any_q;
      is_last_q    <= any_q && last_q;
    end
  end

  assign out_symbol_o = out_symbol_q;
  assign out_count_o  = out_count_q;
  assign is_empty_o   = is_empty_q;
  assign is_last_o    = is_last_q;

endmodule

### rtl/core/byte_histogram_descending_drain.sv
// Top level of the byte histogram: counts symbols and drains them highest first.
// A count item reads the counter, then writes it back; a drain item picks the row, then
// picks the symbol with a counter read, then loads the result, as the registered reads
// of the counter RAM and the bitmap row RAM require. Results wait in an output register.
// Reset clears the row summary flops, so every counter reads as zero at once; the
// RAMs need no clearing pass and items are accepted right after reset.
`timescale 1ns / 1ps

module byte_histogram_descending_drain #(
  parameter int unsigned SYMBOL_BITS = 8,  // counters held: 2**SYMBOL_BITS
  parameter int unsigned COUNT_BITS  = 16  // width of each saturating counter
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] symbol
  input  logic        s_axis_tuser_i,  // [0] kind: 0 count, 1 drain

  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [7:0] out_symbol, [23:8] out_count
  output logic        m_axis_tuser_o,  // [0] is_empty
  output logic        m_axis_tlast_o   // is_last
);

  bhd_pkg::cmd_t cmd;

  logic [bhd_pkg::OUT_SYMBOL_W-1:0] out_symbol;
  logic [bhd_pkg::OUT_COUNT_W-1:0]  out_count;

  // The controller walks each item through its RAM accesses and holds the
  // output valid; it goes back to taking items as soon as a result is loaded,
  // so a count item can be accepted while a drained result waits downstream.
  bhd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_kind_i   (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  // The datapath keeps the counters in one RAM and a nonzero bitmap in a second
  // RAM organized as rows, plus one summary flop per row. A drain finds the
  // highest row with its summary set, then the highest set bit in that row.
  bhd_datapath #(
    .SYMBOL_BITS (SYMBOL_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_symbol_i  (s_axis_tdata_i),
    .out_symbol_o (out_symbol),
    .out_count_o  (out_count),
    .is_empty_o   (m_axis_tuser_o),
    .is_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {out_count, out_symbol};

endmodule

### sim/byte_histogram_descending_drain_tb.sv
// Self-checking testbench for the byte histogram with descending drain.
`timescale 1ns / 1ps

module byte_histogram_descending_drain_tb;

  localparam int unsigned TAIL_CYCLES = 8;       // covers a count item still in flight
  localparam int unsigned RANDOM_ITEMS = 1880;

  // One drain result as the block should present it.
  typedef struct packed {
    logic [bhd_pkg::OUT_SYMBOL_W-1:0] sym;
    logic [bhd_pkg::OUT_COUNT_W-1:0]  cnt;
    logic                             empty;
    logic                             last;
  } drain_result_t;

  // Tracks the counters and the queue of drain results still owed by the block.
  class hist_scoreboard;
    logic [bhd_pkg::OUT_COUNT_W-1:0] tally [256];
    drain_result_t awaited [$];
    int unsigned errors, counts_seen, drains_seen, results_seen, empties_seen;

    function new();
      foreach (tally[i]) tally[i] = '0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function int unsigned nonzero_entries();
      int unsigned n;
      n = 0;
      foreach (tally[i]) if (tally[i] != '0) n++;
      return n;
    endfunction

    // Updates the counters for an accepted item; a drain queues its result.
    function void note_item(logic kind, logic [7:0] sym);
      drain_result_t r;
      int top;
      if (kind == bhd_pkg::KIND_COUNT) begin
        counts_seen++;
        if (tally[sym] != '1) tally[sym] = tally[sym] + 1'b1;
        return;
      end
      drains_seen++;
      top = -1;
      for (int i = 255; i >= 0; i--) if (top < 0 && tally[i] != '0) top = i;
      r = '0;
      if (top < 0) begin
        r.empty = 1'b1;
      end else begin
        r.sym = 8'(top);
        r.cnt = tally[top];
        tally[top] = '0;
        r.last = 1'b1;
        for (int i = top - 1; i >= 0; i--) if (tally[i] != '0) r.last = 1'b0;
      end
      awaited.push_back(r);
    endfunction

    function void check_result(logic [7:0] sym, logic [15:0] cnt, logic empty, logic last);
      drain_result_t exp;
      results_seen++;
      if (empty) empties_seen++;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result sym=%02h cnt=%0d empty=%0b last=%0b",
                       sym, cnt, empty, last));
        return;
      end
      exp = awaited.pop_front();
      if (sym !== exp.sym || cnt !== exp.cnt || empty !== exp.empty || last !== exp.last)
        flag($sformatf({"result %0d: expected sym=%02h cnt=%0d empty=%0b last=%0b,",
                        " got sym=%02h cnt=%0d empty=%0b last=%0b"},
                       results_seen, exp.sym, exp.cnt, exp.empty, exp.last,
                       sym, cnt, empty, last));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = bhd_pkg::KIND_COUNT;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  bit calm = 1'b0;               // when set, neither side idles
  int unsigned items_sent = 0;
  hist_scoreboard sb;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  byte_histogram_descending_drain uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Result side: check what was accepted at this edge, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready)
      sb.check_result(m_axis_tdata_o[7:0], m_axis_tdata_o[23:8],
                      m_axis_tuser_o, m_axis_tlast_o);
    m_ready <= calm || ($urandom_range(99) >= 30);
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #60_000_000;
    $display("FAILURE");
    $finish;
  end

  // Presents one item, with random idle cycles ahead of it, and waits for acceptance.
  // Valid stays high after acceptance so back-to-back items need no extra assignment.
  task automatic send_item(input logic kind, input logic [7:0] sym);
    if (!calm) begin
      while ($urandom_range(99) < 30) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_item(kind, sym);
    items_sent++;
  endtask

  // Holds the input idle until every owed result has arrived, then lets the
  // pipeline settle.
  task automatic pause_until_drained();
    int unsigned guard;
    s_tvalid <= 1'b0;
    guard = 0;
    while (sb.awaited.size() != 0 && guard < 200_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Mixes the full byte range with tight clusters at both ends so counts repeat.
  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(2))
      0:       return 8'($urandom_range(255));
      1:       return 8'hF8 | 8'($urandom_range(7));
      default: return 8'($urandom_range(7));
    endcase
  endfunction

  initial begin
    int unsigned rand_start, n, k;
    bit paused;
    sb = new();
    paused = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: drains of an empty store, then the extreme symbols and each bit.
    send_item(bhd_pkg::KIND_DRAIN, 8'h00);
    send_item(bhd_pkg::KIND_DRAIN, 8'hFF);
    send_item(bhd_pkg::KIND_COUNT, 8'h00);
    send_item(bhd_pkg::KIND_COUNT, 8'hFF);
    send_item(bhd_pkg::KIND_COUNT, 8'hFF);
    send_item(bhd_pkg::KIND_COUNT, 8'h80);
    send_item(bhd_pkg::KIND_COUNT, 8'h01);
    send_item(bhd_pkg::KIND_COUNT, 8'h7F);
    send_item(bhd_pkg::KIND_COUNT, 8'h55);
    send_item(bhd_pkg::KIND_COUNT, 8'hAA);
    // Drain everything, one more than there are entries to see the empty flag.
    repeat (8) send_item(bhd_pkg::KIND_DRAIN, 8'h00);
    // Count followed at once by a drain of the same symbol.
    send_item(bhd_pkg::KIND_COUNT, 8'hFF);
    send_item(bhd_pkg::KIND_DRAIN, 8'h5A);
    send_item(bhd_pkg::KIND_DRAIN, 8'hA5);

    // Random: mostly fill-then-drain runs, with noise in between.
    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      calm = (items_sent - rand_start >= 600) && (items_sent - rand_start < 900);
      if (!paused && items_sent - rand_start >= 1200) begin
        pause_until_drained();
        paused = 1'b1;
      end
      if ($urandom_range(9) < 7) begin
        n = $urandom_range(40, 1);
        repeat (n) send_item(bhd_pkg::KIND_COUNT, pick_symbol());
        k = sb.nonzero_entries() + (($urandom_range(3) == 0) ? 1 : 0);
        if ($urandom_range(4) == 0) k = $urandom_range(k);
        repeat (k) send_item(bhd_pkg::KIND_DRAIN, 8'($urandom_range(255)));
      end else begin
        n = $urandom_range(20, 1);
        repeat (n) send_item(logic'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
    calm = 1'b0;

    pause_until_drained();
    if (sb.awaited.size() != 0)
      sb.flag($sformatf("%0d drain results never arrived", sb.awaited.size()));

    $display("Run covered %0d items: %0d counts and %0d drains.",
             items_sent, sb.counts_seen, sb.drains_seen);
    $display("Checked %0d results, %0d of them empty; %0d mismatches.",
             sb.results_seen, sb.empties_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
